/* hw/rtl/spm_pkg.sv */
// ----------------------------------------------------------------------------
// spm_pkg : shared types and constants of the sparse polynomial adder
// term layout, function codes, controller states and command/status groups
// ----------------------------------------------------------------------------
package spm_pkg;

	localparam int MAX_TERMS_DEF = 32;
	localparam int FUNC_W        = 2;
	localparam int EXP_W         = 16;
	localparam int COEF_W        = 32;

	localparam logic [FUNC_W-1:0] FUNC_LOAD_FIRST  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_SECOND = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RUN         = 2'd2;

	localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7fff_ffff;
	localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [EXP_W-1:0]         exp;
		logic signed [COEF_W-1:0] coef;
	} term_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_STEP,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic wr_first;
		logic wr_second;
		logic start;
		logic step;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic done;
		logic step_ok;
		logic out_free;
	} sts_t;

endpackage

/* hw/rtl/sparse_poly_add_merge_top.sv */
// ----------------------------------------------------------------------------
// sparse_poly_add_merge_top : sparse polynomial adder by sorted merge
// loads two term lists, then merges them by exponent with saturating sums
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------
//  in      | in_valid / in_ready  | func, exp, coef
//  out     | out_valid / out_ready| out_exp, out_coef, last, empty_res
//
//  transactions are taken only when idle; a run starts from idle, then for
//  each merge step reads the term stores (registered, in fetch) and then
//  compares and adds (in step), until a fetch finds both lists spent and the
//  closing state ends the run once the output register is free
//  each merged term leaves through the output register, one held back so the
//  final term can carry last; a busy output register stalls the step
//  reset clears the counts and the sequencer; term stores need no clearing
//
module sparse_poly_add_merge_top #(
	parameter int MAX_TERMS = spm_pkg::MAX_TERMS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [spm_pkg::FUNC_W-1:0]         func,
	input  logic [spm_pkg::EXP_W-1:0]          exp,
	input  logic signed [spm_pkg::COEF_W-1:0]  coef,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [spm_pkg::EXP_W-1:0]          out_exp,
	output logic signed [spm_pkg::COEF_W-1:0]  out_coef,
	output logic                               last,
	output logic                               empty_res
);

	// command and status groups between sequencer and datapath
	spm_pkg::cmd_t cmd;
	spm_pkg::sts_t sts;

	// sequencer: idle, fetch, step, finish
	spm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.sts      (sts),
		.cmd      (cmd)
	);

	// term stores, merge pointers and output register
	spm_dp #(
		.MAX_TERMS (MAX_TERMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.exp       (exp),
		.coef      (coef),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_exp   (out_exp),
		.out_coef  (out_coef),
		.last      (last),
		.empty_res (empty_res)
	);

`ifndef SYNTHESIS
	// an empty result is always the closing transaction of its run
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!empty_res || last))
		else $error("empty result without last");

	// the sequencer is back in idle right after closing a run
	a_finish_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> in_ready)
		else $error("not idle after run close");

	// a merge step never coincides with the closing of a run
	a_step_not_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step && cmd.finish))
		else $error("step and finish together");

	// a run start is taken only from an accepted transaction
	a_start_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> (in_valid && in_ready))
		else $error("run start without transaction");
`endif

endmodule

/* hw/rtl/spm_ctrl.sv */
// ----------------------------------------------------------------------------
// spm_ctrl : merge sequencer
// takes transactions in idle, then walks fetch/step until both lists are spent
// ----------------------------------------------------------------------------
module spm_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [spm_pkg::FUNC_W-1:0]   func,
	input  spm_pkg::sts_t                sts,
	output spm_pkg::cmd_t                cmd
);

	spm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			spm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (func)
						spm_pkg::FUNC_LOAD_FIRST:  cmd.wr_first  = 1'b1;
						spm_pkg::FUNC_LOAD_SECOND: cmd.wr_second = 1'b1;
						spm_pkg::FUNC_RUN: begin
							cmd.start = 1'b1;
							state_d   = spm_pkg::ST_FETCH;
						end
						default: ;
					endcase
				end
			end
			spm_pkg::ST_FETCH: begin
				state_d = sts.done ? spm_pkg::ST_FINISH : spm_pkg::ST_STEP;
			end
			spm_pkg::ST_STEP: begin
				if (sts.step_ok) begin
					cmd.step = 1'b1;
					state_d  = spm_pkg::ST_FETCH;
				end
			end
			spm_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = spm_pkg::ST_IDLE;
				end
			end
			default: state_d = spm_pkg::ST_IDLE;
		endcase
	end

endmodule

/* hw/rtl/spm_dp.sv */
// ----------------------------------------------------------------------------
// spm_dp : term stores, merge pointers, saturating adder and output register
// one result is held back so the final one can be marked
// ----------------------------------------------------------------------------
module spm_dp #(
	parameter int MAX_TERMS = spm_pkg::MAX_TERMS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spm_pkg::cmd_t                      cmd,
	output spm_pkg::sts_t                      sts,
	input  logic [spm_pkg::EXP_W-1:0]          exp,
	input  logic signed [spm_pkg::COEF_W-1:0]  coef,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [spm_pkg::EXP_W-1:0]          out_exp,
	output logic signed [spm_pkg::COEF_W-1:0]  out_coef,
	output logic                               last,
	output logic                               empty_res
);

	localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W  = $clog2(MAX_TERMS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_TERMS);

	spm_pkg::term_t mem_a [MAX_TERMS];
	spm_pkg::term_t mem_b [MAX_TERMS];
	spm_pkg::term_t rd_a_q, rd_b_q;

	logic [CNT_W-1:0] na_q, nb_q, i_q, j_q;

	spm_pkg::term_t pend_q;
	logic           pend_v_q;

	logic                              out_v_q;
	logic [spm_pkg::EXP_W-1:0]         out_exp_q;
	logic signed [spm_pkg::COEF_W-1:0] out_coef_q;
	logic                              out_last_q, out_empty_q;

	logic           a_ok, b_ok, take_a, take_b;
	logic [spm_pkg::COEF_W:0] sum;
	spm_pkg::term_t cand;
	logic           cand_nz, out_free, nz_in;

	assign nz_in = (coef != '0);

	// term stores, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_first && nz_in && (na_q < CNT_FULL)) begin
			mem_a[na_q[ADDR_W-1:0]] <= '{exp: exp, coef: coef};
		end
		if (cmd.wr_second && nz_in && (nb_q < CNT_FULL)) begin
			mem_b[nb_q[ADDR_W-1:0]] <= '{exp: exp, coef: coef};
		end
		rd_a_q <= mem_a[i_q[ADDR_W-1:0]];
		rd_b_q <= mem_b[j_q[ADDR_W-1:0]];
	end

	// head compare and saturating add
	always_comb begin
		a_ok   = (i_q < na_q);
		b_ok   = (j_q < nb_q);
		take_a = a_ok && (!b_ok || (rd_a_q.exp <= rd_b_q.exp));
		take_b = b_ok && (!a_ok || (rd_b_q.exp <= rd_a_q.exp));
		sum    = {rd_a_q.coef[spm_pkg::COEF_W-1], rd_a_q.coef}
		       + {rd_b_q.coef[spm_pkg::COEF_W-1], rd_b_q.coef};
		if (take_a && take_b) begin
			cand.exp = rd_a_q.exp;
			if (sum[spm_pkg::COEF_W] != sum[spm_pkg::COEF_W-1]) begin
				cand.coef = sum[spm_pkg::COEF_W] ? spm_pkg::COEF_MIN : spm_pkg::COEF_MAX;
			end else begin
				cand.coef = sum[spm_pkg::COEF_W-1:0];
			end
		end else if (take_a) begin
			cand = rd_a_q;
		end else begin
			cand = rd_b_q;
		end
		cand_nz  = (cand.coef != '0);
		out_free = !out_v_q || out_ready;
	end

	assign sts.done     = !a_ok && !b_ok;
	assign sts.out_free = out_free;
	assign sts.step_ok  = !cand_nz || !pend_v_q || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			na_q     <= '0;
			nb_q     <= '0;
			i_q      <= '0;
			j_q      <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			// a new result loads the output register, else it empties when taken
			if (cmd.finish || (cmd.step && cand_nz && pend_v_q)) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			if (cmd.wr_first && nz_in && (na_q < CNT_FULL)) begin
				na_q <= CNT_W'(na_q + 1'b1);
			end
			if (cmd.wr_second && nz_in && (nb_q < CNT_FULL)) begin
				nb_q <= CNT_W'(nb_q + 1'b1);
			end
			if (cmd.start) begin
				i_q      <= '0;
				j_q      <= '0;
				pend_v_q <= 1'b0;
			end
			if (cmd.step) begin
				if (take_a) i_q <= CNT_W'(i_q + 1'b1);
				if (take_b) j_q <= CNT_W'(j_q + 1'b1);
				if (cand_nz) begin
					pend_v_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				pend_v_q <= 1'b0;
				na_q     <= '0;
				nb_q     <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.step && cand_nz) begin
			pend_q <= cand;
			if (pend_v_q) begin
				out_exp_q   <= pend_q.exp;
				out_coef_q  <= pend_q.coef;
				out_last_q  <= 1'b0;
				out_empty_q <= 1'b0;
			end
		end
		if (cmd.finish) begin
			out_last_q <= 1'b1;
			if (pend_v_q) begin
				out_exp_q   <= pend_q.exp;
				out_coef_q  <= pend_q.coef;
				out_empty_q <= 1'b0;
			end else begin
				out_exp_q   <= '0;
				out_coef_q  <= '0;
				out_empty_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_exp   = out_exp_q;
	assign out_coef  = out_coef_q;
	assign last      = out_last_q;
	assign empty_res = out_empty_q;

endmodule

/* verif/spm_merge_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spm_merge_checker : term store mirror and merged term scoreboard
// watches both channels, keeps its own copy of the two term lists, predicts
// the merged terms of every run and compares each output transaction
// ----------------------------------------------------------------------------
module spm_merge_checker #(
	parameter int MAX_TERMS = spm_pkg::MAX_TERMS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [spm_pkg::FUNC_W-1:0]         func,
	input  logic [spm_pkg::EXP_W-1:0]          exp,
	input  logic signed [spm_pkg::COEF_W-1:0]  coef,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [spm_pkg::EXP_W-1:0]          out_exp,
	input  logic signed [spm_pkg::COEF_W-1:0]  out_coef,
	input  logic                               last,
	input  logic                               empty_res,
	output int                                 errors,
	output int                                 pending,
	output int                                 merged_checked,
	output int                                 empty_checked
);

	typedef struct packed {
		logic [spm_pkg::EXP_W-1:0]         exp;
		logic signed [spm_pkg::COEF_W-1:0] coef;
		logic                              last;
		logic                              is_empty;
	} merged_term_t;

	spm_pkg::term_t first_list [MAX_TERMS];
	spm_pkg::term_t second_list [MAX_TERMS];
	int             first_n;
	int             second_n;
	merged_term_t   merged_q [$];

	function automatic logic signed [spm_pkg::COEF_W-1:0] sat_sum(
		input logic signed [spm_pkg::COEF_W-1:0] a,
		input logic signed [spm_pkg::COEF_W-1:0] b
	);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > longint'(spm_pkg::COEF_MAX))
			return spm_pkg::COEF_MAX;
		if (s < longint'(spm_pkg::COEF_MIN))
			return spm_pkg::COEF_MIN;
		return s[spm_pkg::COEF_W-1:0];
	endfunction

	// zero sums vanish from the merged polynomial
	function automatic void push_term(input logic [spm_pkg::EXP_W-1:0] e,
			input logic signed [spm_pkg::COEF_W-1:0] c);
		if (c != '0)
			merged_q.push_back('{exp: e, coef: c, last: 1'b0, is_empty: 1'b0});
	endfunction

	function automatic void predict_merge();
		int             i;
		int             j;
		int             n0;
		spm_pkg::term_t a;
		spm_pkg::term_t b;
		merged_term_t   t;
		i = 0;
		j = 0;
		n0 = merged_q.size();
		while (i < first_n && j < second_n) begin
			a = first_list[i];
			b = second_list[j];
			if (a.exp == b.exp) begin
				push_term(a.exp, sat_sum(a.coef, b.coef));
				i++;
				j++;
			end else if (a.exp > b.exp) begin
				push_term(b.exp, b.coef);
				j++;
			end else begin
				push_term(a.exp, a.coef);
				i++;
			end
		end
		for (; i < first_n; i++)
			push_term(first_list[i].exp, first_list[i].coef);
		for (; j < second_n; j++)
			push_term(second_list[j].exp, second_list[j].coef);
		if (merged_q.size() == n0) begin
			merged_q.push_back('{exp: '0, coef: '0, last: 1'b1, is_empty: 1'b1});
		end else begin
			t = merged_q.pop_back();
			t.last = 1'b1;
			merged_q.push_back(t);
		end
		first_n = 0;
		second_n = 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		merged_term_t want;
		if (!arst_n) begin
			first_n = 0;
			second_n = 0;
			merged_q.delete();
			errors = 0;
			pending = 0;
			merged_checked = 0;
			empty_checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (merged_q.size() == 0) begin
					$error("unexpected merged term: exp %0d coef %0d", out_exp, out_coef);
					errors++;
				end else begin
					want = merged_q.pop_front();
					merged_checked++;
					if (want.is_empty)
						empty_checked++;
					if (out_exp !== want.exp) begin
						$error("out_exp mismatch: expected %0d, got %0d", want.exp, out_exp);
						errors++;
					end
					if (out_coef !== want.coef) begin
						$error("out_coef mismatch: expected %0d, got %0d", want.coef, out_coef);
						errors++;
					end
					if (last !== want.last) begin
						$error("last mismatch: expected %0d, got %0d", want.last, last);
						errors++;
					end
					if (empty_res !== want.is_empty) begin
						$error("empty_res mismatch: expected %0d, got %0d", want.is_empty,
							empty_res);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				case (func)
					spm_pkg::FUNC_LOAD_FIRST: begin
						if (coef != '0 && first_n < MAX_TERMS) begin
							first_list[first_n] = '{exp: exp, coef: coef};
							first_n++;
						end
					end
					spm_pkg::FUNC_LOAD_SECOND: begin
						if (coef != '0 && second_n < MAX_TERMS) begin
							second_list[second_n] = '{exp: exp, coef: coef};
							second_n++;
						end
					end
					spm_pkg::FUNC_RUN: predict_merge();
					default: ;
				endcase
			end
			pending = merged_q.size();
		end
	end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb : testbench of the sparse polynomial adder
// drives load and run transactions through random idling phases and a long
// output hold-off; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb;

	localparam int                          ITEMS       = 260;
	localparam int                          HOLD_CYCLES = 300;
	localparam int                          IDLE_LIMIT  = 3000;
	localparam int                          TAIL_CYCLES = 20;
	// code with no meaning to the block, it must be swallowed silently
	localparam logic [spm_pkg::FUNC_W-1:0]  FUNC_UNUSED = 2'd3;

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_ready;
	logic [spm_pkg::FUNC_W-1:0]         func;
	logic [spm_pkg::EXP_W-1:0]          exp;
	logic signed [spm_pkg::COEF_W-1:0]  coef;
	logic                               out_valid;
	logic                               out_ready;
	logic [spm_pkg::EXP_W-1:0]          out_exp;
	logic signed [spm_pkg::COEF_W-1:0]  out_coef;
	logic                               last;
	logic                               empty_res;

	int errors;
	int pending;
	int merged_checked;
	int empty_checked;

	// stimulus knobs, percentages of cycles spent idle or stalled
	int send_idle_pct;
	int stall_pct;
	int items_sent;
	int runs_sent;
	int idle_cycles;
	// hold-off request, toggled by the stimulus and followed by the receiver
	logic hold_req;
	logic hold_seen;

	sparse_poly_add_merge_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.exp       (exp),
		.coef      (coef),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_exp   (out_exp),
		.out_coef  (out_coef),
		.last      (last),
		.empty_res (empty_res)
	);

	spm_merge_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.exp            (exp),
		.coef           (coef),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_exp        (out_exp),
		.out_coef       (out_coef),
		.last           (last),
		.empty_res      (empty_res),
		.errors         (errors),
		.pending        (pending),
		.merged_checked (merged_checked),
		.empty_checked  (empty_checked)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// watchdog: a stretch with no transaction on either channel ends the run
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stalls at the falling edge, plus one long hold-off
	// counted here so the block fills and pushes back on its input
	initial begin
		out_ready = 1'b0;
		hold_seen = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// one input transaction: optional idle gap, then valid held until taken;
	// valid is left high afterwards so back-to-back items need no re-raise
	task automatic offer(input logic [spm_pkg::FUNC_W-1:0] f,
			input logic [spm_pkg::EXP_W-1:0] e,
			input logic signed [spm_pkg::COEF_W-1:0] c);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		exp      <= e;
		coef     <= c;
		do
			@(posedge clk);
		while (!in_ready);
		if (f != FUNC_UNUSED)
			items_sent++;
		if (f == spm_pkg::FUNC_RUN)
			runs_sent++;
	endtask

	// sender pause until the checker has nothing outstanding; valid drops first
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// coefficient mix weighted towards the saturation corners and zero
	function automatic logic signed [spm_pkg::COEF_W-1:0] pick_coef();
		case ($urandom_range(15))
			0:       return spm_pkg::COEF_MAX;
			1:       return spm_pkg::COEF_MIN;
			2:       return '0;
			3, 4:    return 32'($urandom_range(131071)) - 32'sd65536;
			default: return $urandom;
		endcase
	endfunction

	// one pair of ascending lists (order broken now and then), shared exponents included,
	// loaded in random interleave with some noise, then usually a run
	task automatic merge_trial(input int max_len);
		logic [spm_pkg::EXP_W-1:0]         fe [$];
		logic [spm_pkg::EXP_W-1:0]         se [$];
		logic signed [spm_pkg::COEF_W-1:0] fc [$];
		logic signed [spm_pkg::COEF_W-1:0] sc [$];
		logic signed [spm_pkg::COEF_W-1:0] c;
		logic [spm_pkg::EXP_W-1:0]         te;
		int na;
		int nb;
		int max_step;
		int e;
		int pick;
		int ia;
		int ib;
		na = $urandom_range(max_len);
		nb = $urandom_range(max_len);
		max_step = 65535 / (na + nb + 1);
		e = $urandom_range(65535 - (na + nb) * max_step);
		while (fe.size() < na || se.size() < nb) begin
			// an occasional zero step can give a repeated exponent in one list
			if ($urandom_range(15) != 0)
				e += $urandom_range(1, max_step);
			pick = $urandom_range(2);
			if (fe.size() == na)
				pick = 1;
			else if (se.size() == nb)
				pick = 0;
			c = pick_coef();
			if (pick != 1) begin
				fe.push_back(16'(e));
				fc.push_back(c);
			end
			if (pick != 0) begin
				se.push_back(16'(e));
				case ($urandom_range(7))
					0, 1:    sc.push_back(-c);
					2:       sc.push_back(c);
					default: sc.push_back(pick_coef());
				endcase
			end
		end
		// broken order now and then: swap two terms of the first list
		if (na >= 2 && $urandom_range(7) == 0) begin
			ia = $urandom_range(na - 1);
			ib = $urandom_range(na - 1);
			te = fe[ia];
			fe[ia] = fe[ib];
			fe[ib] = te;
		end
		ia = 0;
		ib = 0;
		while (ia < fe.size() || ib < se.size()) begin
			if ($urandom_range(9) == 0)
				offer(FUNC_UNUSED, 16'($urandom), $urandom);
			if (ib == se.size() || (ia < fe.size() && $urandom_range(1) == 1)) begin
				offer(spm_pkg::FUNC_LOAD_FIRST, fe[ia], fc[ia]);
				ia++;
			end else begin
				offer(spm_pkg::FUNC_LOAD_SECOND, se[ib], sc[ib]);
				ib++;
			end
		end
		// skipping the run now and then lets the lists carry over
		if ($urandom_range(11) != 0)
			offer(spm_pkg::FUNC_RUN, 16'($urandom), $urandom);
	endtask

	initial begin
		int start;
		int target;
		int ph;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		func          = spm_pkg::FUNC_LOAD_FIRST;
		exp           = '0;
		coef          = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		items_sent    = 0;
		runs_sent     = 0;
		hold_req      = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: run on nothing gives the empty marker
		offer(spm_pkg::FUNC_RUN, '0, '0);
		// saturation both ways, cancelling sum, zero-coefficient drop, unused code
		offer(spm_pkg::FUNC_LOAD_FIRST, 16'd0, spm_pkg::COEF_MAX);
		offer(spm_pkg::FUNC_LOAD_FIRST, 16'd5, -32'sd1);
		offer(spm_pkg::FUNC_LOAD_FIRST, 16'd9, '0);
		offer(spm_pkg::FUNC_LOAD_FIRST, 16'hffff, spm_pkg::COEF_MIN);
		offer(spm_pkg::FUNC_LOAD_SECOND, 16'd0, 32'sd1);
		offer(spm_pkg::FUNC_LOAD_SECOND, 16'd5, 32'sd1);
		offer(FUNC_UNUSED, 16'hffff, spm_pkg::COEF_MIN);
		offer(spm_pkg::FUNC_LOAD_SECOND, 16'hffff, -32'sd1);
		offer(spm_pkg::FUNC_RUN, 16'hffff, spm_pkg::COEF_MAX);
		// lists out of order are merged as they stand
		offer(spm_pkg::FUNC_LOAD_FIRST, 16'd10, 32'sd3);
		offer(spm_pkg::FUNC_LOAD_FIRST, 16'd3, 32'sh0001_8000);
		offer(spm_pkg::FUNC_LOAD_SECOND, 16'd7, -32'sh0001_0000);
		offer(spm_pkg::FUNC_RUN, '0, '0);
		// every term cancels, so the merge is empty
		offer(spm_pkg::FUNC_LOAD_FIRST, 16'd4, 32'sd2);
		offer(spm_pkg::FUNC_LOAD_SECOND, 16'd4, -32'sd2);
		offer(spm_pkg::FUNC_RUN, '0, '0);
		// only the second list filled
		offer(spm_pkg::FUNC_LOAD_SECOND, 16'h8000, 32'sh7fff_0000);
		offer(spm_pkg::FUNC_RUN, '0, '0);
		drain();

		// long output hold-off while loads and runs keep coming
		hold_req = ~hold_req;
		merge_trial(12);
		offer(spm_pkg::FUNC_RUN, '0, '0);
		merge_trial(12);
		drain();

		// idling phases: none, sender idle, receiver stalling, both lightly
		start = items_sent;
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 80; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 80; end
				default: begin send_idle_pct = 20; stall_pct = 20; end
			endcase
			target = start + (ph + 1) * (ITEMS - start) / 4;
			while (items_sent < target)
				merge_trial(($urandom_range(9) == 0) ? 36 : 6);
			offer(spm_pkg::FUNC_RUN, '0, '0);
			drain();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("covered %0d input transactions and %0d runs through four idling phases",
			items_sent, runs_sent);
		$display("checked %0d merged terms, %0d of them empty merges", merged_checked,
			empty_checked);
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
